### sv/lcs_length_engine_macros.svh
// Assertion macros shared by the LCS length engine RTL.
// Included by the files that carry concurrent assertions; needs no package.
`ifndef LCS_LENGTH_ENGINE_MACROS_SVH
`define LCS_LENGTH_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcs_length_engine: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define LCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcs_length_engine: next-cycle check failed");
`else
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/lcs_pkg.sv
// Package for the LCS length engine: action codes, field widths and the cell control word.
// Used by lcs_cell and lcs_length_engine; depends on nothing else.
`timescale 1ns / 1ps

package lcs_pkg;

    // Field widths fixed by the stream format.
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 7;
    localparam int LEN_MAX = 127;

    // Kind of an input word, carried in tuser.
    typedef enum logic [1:0] {
        ACT_FIRST  = 2'd0,
        ACT_SECOND = 2'd1,
        ACT_FINISH = 2'd2
    } lcs_action_t;

    // Control from the top level to each cell: clear and load_char are broadcast, load selects one cell.
    typedef struct packed {
        logic              clear;
        logic              load;
        logic [CHAR_W-1:0] load_char;
    } lcs_cell_ctrl_t;

endpackage

### sv/lcs_cell.sv
// One cell of the LCS systolic row: holds one first-string character and its DP count.
// Depends on lcs_pkg for the control word and the character width.
`timescale 1ns / 1ps

module lcs_cell #(
    parameter int CW = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcs_pkg::lcs_cell_ctrl_t     ctrl,
    input  logic                        in_valid,
    input  logic [lcs_pkg::CHAR_W-1:0]  in_char,
    input  logic [CW-1:0]               in_left,
    input  logic [CW-1:0]               in_diag,
    output logic                        out_valid,
    output logic [lcs_pkg::CHAR_W-1:0]  out_char,
    output logic [CW-1:0]               out_left,
    output logic [CW-1:0]               out_diag
);
    import lcs_pkg::*;

    logic              held_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [CW-1:0]     row_reg;
    logic [CW-1:0]     row_next;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CW-1:0]     out_left_reg;
    logic [CW-1:0]     out_diag_reg;

    // DP update: a match takes the diagonal plus one, otherwise the larger of
    // the upper and left counts. An empty cell passes the left count through.
    always_comb
    begin
        if (!held_reg)
        begin
            row_next = in_left;
        end
        else if (char_reg == in_char)
        begin
            row_next = in_diag + CW'(1);
        end
        else if (row_reg > in_left)
        begin
            row_next = row_reg;
        end
        else
        begin
            row_next = in_left;
        end
    end

    // Cell state: occupancy and row count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
            row_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            held_reg <= 1'b0;
            row_reg  <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                held_reg <= 1'b1;
            end
            if (in_valid && held_reg)
            begin
                row_reg <= row_next;
            end
        end
    end

    // The held character needs no reset; it is only compared once loaded.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            char_reg <= ctrl.load_char;
        end
    end

    // Hand-off stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            out_char_reg <= in_char;
            out_left_reg <= row_next;
            out_diag_reg <= row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_left  = out_left_reg;
    assign out_diag  = out_diag_reg;

endmodule

### sv/lcs_length_engine.sv
// Top level of the LCS length engine: stream control and a row of MAX_LEN lcs_cell stages.
// Depends on lcs_pkg, lcs_cell and lcs_length_engine_macros.svh.
//
//  Port group   Dir  Word contents (low bit first)
//  s_axis_*     in   tuser: action[1:0]; tdata: ch[7:0]
//  m_axis_*     out  tdata: lcs_length[6:0], zero pad[7]; tuser: truncated[0]
//
// One input word is taken per cycle while s_axis_tready is high. A second-string
// character walks the row one cell per cycle, so a finish word waits until the
// last character has passed all MAX_LEN cells.
// A finish word also waits while the previous result has not been taken.
// Reset clears every cell at once; there is no clearing pass.
`timescale 1ns / 1ps
`include "lcs_length_engine_macros.svh"

module lcs_length_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // ch[7:0]
    input  logic [1:0] s_axis_tuser,   // action[1:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // lcs_length[6:0], zero pad[7]
    output logic [0:0] m_axis_tuser    // truncated[0]
);
    import lcs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int EW = (CW > LEN_W) ? CW : LEN_W;

    logic              acc;
    logic              first_acc;
    logic              load_acc;
    logic              second_acc;
    logic              finish_acc;
    logic              full;

    logic [CW-1:0]     first_count_reg;
    logic [CW-1:0]     first_count_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              second_begun_reg;
    logic              second_begun_next;
    logic [CW-1:0]     drain_cnt_reg;
    logic [CW-1:0]     drain_cnt_next;
    logic [CW-1:0]     result_reg;
    logic [CW-1:0]     result_next;
    logic              m_valid_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic              m_trunc_reg;
    logic [EW-1:0]     result_ext;
    logic [LEN_W-1:0]  len_sat;

    logic              vld [0:MAX_LEN];
    logic [CHAR_W-1:0] chr [0:MAX_LEN];
    logic [CW-1:0]     lft [0:MAX_LEN];
    logic [CW-1:0]     dia [0:MAX_LEN];
    lcs_cell_ctrl_t    ctrl_arr [0:MAX_LEN-1];

    // A finish word needs an empty row and a free output register.
    assign s_axis_tready = (s_axis_tuser != ACT_FINISH) ||
                           ((drain_cnt_reg == '0) && (!m_valid_reg || m_axis_tready));
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign full = (first_count_reg == CW'(MAX_LEN));

    // Decode the accepted word.
    always_comb
    begin
        first_acc  = 1'b0;
        second_acc = 1'b0;
        finish_acc = 1'b0;
        case (s_axis_tuser)
            ACT_FIRST:  first_acc  = acc && !second_begun_reg;
            ACT_SECOND: second_acc = acc;
            ACT_FINISH: finish_acc = acc;
            default:    ;
        endcase
    end
    assign load_acc = first_acc && !full;

    // Control state updates.
    always_comb
    begin
        first_count_next  = first_count_reg;
        overflow_next     = overflow_reg;
        second_begun_next = second_begun_reg;
        drain_cnt_next    = drain_cnt_reg;
        result_next       = result_reg;
        if (drain_cnt_reg != '0)
        begin
            drain_cnt_next = drain_cnt_reg - CW'(1);
        end
        if (load_acc)
        begin
            first_count_next = first_count_reg + CW'(1);
        end
        if (first_acc && full)
        begin
            overflow_next = 1'b1;
        end
        if (second_acc)
        begin
            second_begun_next = 1'b1;
            drain_cnt_next    = CW'(MAX_LEN);
        end
        // The count leaving the last cell is the entry of the last held character.
        if (vld[MAX_LEN])
        begin
            result_next = lft[MAX_LEN];
        end
        if (finish_acc)
        begin
            first_count_next  = '0;
            overflow_next     = 1'b0;
            second_begun_next = 1'b0;
            result_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            overflow_reg     <= 1'b0;
            second_begun_reg <= 1'b0;
            drain_cnt_reg    <= '0;
            result_reg       <= '0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            overflow_reg     <= overflow_next;
            second_begun_reg <= second_begun_next;
            drain_cnt_reg    <= drain_cnt_next;
            result_reg       <= result_next;
        end
    end

    // Saturate the length to the output field.
    assign result_ext = EW'(result_reg);
    assign len_sat    = (result_ext > EW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : result_ext[LEN_W-1:0];

    // Output register: holds the result word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (finish_acc)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_acc)
        begin
            m_len_reg   <= len_sat;
            m_trunc_reg <= overflow_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_len_reg};
    assign m_axis_tuser  = m_trunc_reg;

    // Head of the row: a new character enters with zero left and diagonal counts.
    assign vld[0] = second_acc;
    assign chr[0] = s_axis_tdata;
    assign lft[0] = '0;
    assign dia[0] = '0;

    // Row of cells; cell i holds first-string character i.
    for (genvar gi = 0; gi < MAX_LEN; gi++)
    begin : g_cell
        assign ctrl_arr[gi] = '{clear:     finish_acc,
                                load:      load_acc && (first_count_reg == CW'(gi)),
                                load_char: s_axis_tdata};

        lcs_cell #(
            .CW (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl_arr[gi]),
            .in_valid  (vld[gi]),
            .in_char   (chr[gi]),
            .in_left   (lft[gi]),
            .in_diag   (dia[gi]),
            .out_valid (vld[gi+1]),
            .out_char  (chr[gi+1]),
            .out_left  (lft[gi+1]),
            .out_diag  (dia[gi+1])
        );
    end

    // A finish is only taken once the row has drained.
    `LCS_ASSERT_IMP(a_finish_drained, clk, rst_n, finish_acc, drain_cnt_reg == '0)
    // A second-string character restarts the drain count at the row length.
    `LCS_ASSERT_NXT(a_drain_restart, clk, rst_n, second_acc, drain_cnt_reg == CW'(MAX_LEN))
    // A finish leaves a pending result and cleared string state.
    `LCS_ASSERT_NXT(a_finish_clears, clk, rst_n, finish_acc,
                    m_valid_reg && (first_count_reg == '0) && !overflow_reg)
    // The length can never exceed the number of held characters.
    `LCS_ASSERT_IMP(a_result_bound, clk, rst_n, 1'b1, result_reg <= first_count_reg)

endmodule

### tb/lcs_length_engine_tb.sv
// Self-checking testbench for lcs_length_engine: streams first and second strings and
// finish words, and checks each emitted LCS length and truncation flag against a DP model.
// Depends on lcs_pkg and the lcs_length_engine RTL.
`timescale 1ns / 1ps

module lcs_length_engine_tb;

    import lcs_pkg::*;

    localparam int DEPTH        = 64;      // MAX_LEN of the instance under test
    localparam int WORD_TARGET  = 1800;    // words that change state, random part
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 600;     // long receiver hold-off
    localparam int HOLD_AFTER   = 700;     // words taken before the hold-off starts

    // Action code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [CHAR_W-1:0] ch;
    } stream_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             trunc;
    } lcs_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;
    logic [1:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic [0:0]       m_axis_tuser;

    lcs_length_engine #(
        .MAX_LEN(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Words waiting to be sent and results waiting to arrive.
    stream_word_t pending_words[$];
    lcs_result_t  pending_lengths[$];

    // Model state: held first string, DP row and flags.
    logic [CHAR_W-1:0] held_chars[DEPTH];
    int                held_count = 0;
    int                dp_row[DEPTH];
    bit                chars_dropped = 1'b0;
    bit                second_seen = 1'b0;

    int words_taken = 0;
    int results_seen = 0;
    int trunc_results = 0;
    int longest_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles before the next word; mostly short, sometimes the full range.
    function automatic int draw_gap(bit quiet);
        if (quiet)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    function automatic void push_word(logic [1:0] action, logic [CHAR_W-1:0] ch);
        stream_word_t w;
        w.action = action;
        w.ch     = ch;
        pending_words.push_back(w);
    endfunction

    // Apply one accepted word to the model; a finish word queues its result and clears.
    task automatic track_lcs_word(stream_word_t w);
        int diag;
        int left;
        int up;
        int val;
        lcs_result_t res;
        case (w.action)
            ACT_FIRST:
            begin
                if (!second_seen)
                begin
                    if (held_count < DEPTH)
                    begin
                        held_chars[held_count] = w.ch;
                        held_count++;
                    end
                    else
                        chars_dropped = 1'b1;
                end
            end
            ACT_SECOND:
            begin
                second_seen = 1'b1;
                diag = 0;
                left = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    up = dp_row[i];
                    if (held_chars[i] == w.ch)
                        val = diag + 1;
                    else
                        val = (up > left) ? up : left;
                    dp_row[i] = val;
                    diag = up;
                    left = val;
                end
            end
            ACT_FINISH:
            begin
                val = (held_count > 0) ? dp_row[held_count - 1] : 0;
                if (val > LEN_MAX)
                    val = LEN_MAX;
                res.length = val[LEN_W-1:0];
                res.trunc  = chars_dropped;
                pending_lengths.push_back(res);
                foreach (dp_row[i])
                    dp_row[i] = 0;
                held_count    = 0;
                chars_dropped = 1'b0;
                second_seen   = 1'b0;
            end
            default:
            begin
                // Reserved action: no effect.
            end
        endcase
    endtask

    // Reset, directed words, then random sequences; then wait for the drain and report.
    initial
    begin
        logic [CHAR_W-1:0] alphabet[3];
        int counted;
        int first_len;
        int second_len;
        bit merge_next;
        logic [CHAR_W-1:0] pick;

        foreach (dp_row[i])
            dp_row[i] = 0;

        // Finish on empty strings.
        push_word(ACT_FINISH, 8'h00);
        // Byte extremes, a late first character, a reserved word in the middle.
        push_word(ACT_FIRST, 8'h00);
        push_word(ACT_FIRST, 8'hFF);
        push_word(ACT_FIRST, 8'hA5);
        push_word(ACT_SECOND, 8'hFF);
        push_word(ACT_SECOND, 8'h5A);
        push_word(ACT_FIRST, 8'h5A);
        push_word(ACT_SECOND, 8'hA5);
        push_word(ACT_RESERVED, 8'h3C);
        push_word(ACT_SECOND, 8'h00);
        push_word(ACT_FINISH, 8'hFF);
        // Second string with no first string.
        push_word(ACT_SECOND, 8'h11);
        push_word(ACT_SECOND, 8'h22);
        push_word(ACT_FINISH, 8'h00);
        // First string with no second string.
        push_word(ACT_FIRST, 8'h7E);
        push_word(ACT_FIRST, 8'h81);
        push_word(ACT_FINISH, 8'h00);
        // Single match, reserved word before the finish.
        push_word(ACT_FIRST, 8'h42);
        push_word(ACT_SECOND, 8'h42);
        push_word(ACT_RESERVED, 8'hC3);
        push_word(ACT_FINISH, 8'h99);

        // Random sequences over a small alphabet so that matches are common.
        counted = 0;
        merge_next = 1'b0;
        while (counted < WORD_TARGET)
        begin
            foreach (alphabet[k])
                alphabet[k] = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0:       first_len = $urandom_range(DEPTH - 4, DEPTH + 6);
                1:       first_len = 0;
                default: first_len = $urandom_range(1, 12);
            endcase
            second_len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);

            for (int i = 0; i < first_len; i++)
            begin
                pick = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : alphabet[$urandom_range(0, 2)];
                push_word(ACT_FIRST, pick);
                if ($urandom_range(0, 29) == 0)
                    push_word(ACT_RESERVED, 8'($urandom_range(0, 255)));
                counted++;
            end
            for (int i = 0; i < second_len; i++)
            begin
                pick = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : alphabet[$urandom_range(0, 2)];
                push_word(ACT_SECOND, pick);
                // Occasionally a first-string character too late to count.
                if ($urandom_range(0, 24) == 0)
                    push_word(ACT_FIRST, alphabet[0]);
                counted++;
            end
            // A missing finish runs this sequence into the next one.
            merge_next = ($urandom_range(0, 11) == 0);
            if (!merge_next)
            begin
                push_word(ACT_FINISH, 8'($urandom_range(0, 255)));
                counted++;
            end
        end
        push_word(ACT_FINISH, 8'h00);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all words to be taken and all results to arrive.
        @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || pending_lengths.size() != 0)
            @(negedge clk);
        repeat (DEPTH + 8) @(negedge clk);

        if (pending_lengths.size() != 0)
        begin
            $display("Missing results: %0d still expected at the end", pending_lengths.size());
            mismatches += pending_lengths.size();
        end

        $display("Sent %0d words; checked %0d results, %0d flagged as truncated.",
                 words_taken, results_seen, trunc_results);
        $display("Longest common subsequence seen: %0d; mismatches: %0d.",
                 longest_seen, mismatches);
        if (mismatches == 0)
            $display("[lcs_length_engine] OK");
        else
            $display("[lcs_length_engine] ERROR");
        $finish;
    end

    // Sender: presents queued words with random gaps, feeding the model on each accept.
    always @(posedge clk)
    begin
        logic         next_valid;
        stream_word_t next_word;
        int           send_wait;
        int           send_count;
        bit           send_quiet;
        if (rst_n)
        begin
            next_valid = s_axis_tvalid;
            next_word  = {s_axis_tuser, s_axis_tdata};
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_lcs_word(next_word);
                words_taken <= words_taken + 1;
                send_count++;
                if (send_count % 50 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                next_valid = 1'b0;
                send_wait  = draw_gap(send_quiet);
            end
            if (!next_valid)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (pending_words.size() != 0)
                begin
                    next_word  = pending_words.pop_front();
                    next_valid = 1'b1;
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tuser  <= next_word.action;
            s_axis_tdata  <= next_word.ch;
        end
    end

    // Long receiver hold-off, once, so that results back up and the input stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && words_taken >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each result word against the oldest expectation.
    always @(posedge clk)
    begin
        lcs_result_t got;
        lcs_result_t want;
        int          recv_wait;
        bit          recv_quiet;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.length = m_axis_tdata[LEN_W-1:0];
                got.trunc  = m_axis_tuser[0];
                results_seen++;
                if (got.trunc === 1'b1)
                    trunc_results++;
                if (int'(got.length) > longest_seen)
                    longest_seen = int'(got.length);
                if (pending_lengths.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result at %0t: length %0d truncated %0b",
                                 $realtime, got.length, got.trunc);
                end
                else
                begin
                    want = pending_lengths.pop_front();
                    if (got.length !== want.length || got.trunc !== want.trunc)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Result %0d at %0t: length/truncated %0d/%0b, got %0d/%0b",
                                     results_seen, $realtime, want.length, want.trunc,
                                     got.length, got.trunc);
                    end
                end
                if (results_seen % 10 == 0)
                    recv_quiet = ($urandom_range(0, 3) == 0);
                recv_wait = draw_gap(recv_quiet);
            end
            else if (recv_wait > 0)
                recv_wait--;
            m_axis_tready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    // Watchdog against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("[lcs_length_engine] ERROR");
            $finish;
        end
    end

endmodule
